### hdl/fpd_pkg.sv
`timescale 1ns / 1ps

package fpd_pkg;

    // CRC-16/MODBUS: reflected polynomial, all-ones start, no final xor
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Head pattern after reset
    localparam logic [7:0] HEAD_FIRST_RST  = 8'hAA;
    localparam logic [7:0] HEAD_SECOND_RST = 8'h55;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND = 2'd1;

    // Result stream: 131 bits of fields padded to whole bytes
    localparam int unsigned M_TDATA_W = 136;

    typedef struct packed {
        logic [31:0] frames_ok;
        logic [31:0] crc_errors;
        logic [31:0] dropped;
    } t_counts;

    // Parser to top: payload store writes, per-byte outcome, frame fields
    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_addr;
        logic [7:0]  wr_data;
        logic        emit;       // good frame with payload: stream it out
        logic        empty_ok;   // good frame without payload
        t_counts     counts_next;
        t_counts     counts;
        logic [7:0]  frame_type;
        logic [7:0]  frame_seq;
        logic [7:0]  frame_len;
    } t_prs_out;

    // Fold one byte into the running CRC
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### hdl/fpd_parser.sv
`timescale 1ns / 1ps

module fpd_parser #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_head_first,
    input  logic [7:0]          i_head_second,
    output fpd_pkg::t_prs_out   o_prs
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_SEQ     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC_LO  = 3'd5;
    localparam logic [2:0] PH_CRC_HI  = 3'd6;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [2:0]       r_phase, n_phase;
    logic             r_held, n_held;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_lo, n_crc_lo;
    fpd_pkg::t_counts r_counts, n_counts;

    logic [2:0] drop_inc;
    logic       bad_crc;
    logic       good_crc;
    logic       wr_en;

    // Next state for one accepted byte
    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_type   = r_type;
        n_len    = r_len;
        n_seq    = r_seq;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        drop_inc = 3'd0;
        bad_crc  = 1'b0;
        good_crc = 1'b0;
        wr_en    = 1'b0;
        if (i_take) begin
            case (r_phase)
                PH_HUNT: begin
                    if (r_held) begin
                        if (i_byte == i_head_second) begin
                            n_held  = 1'b0;
                            n_crc   = fpd_pkg::CRC_INIT;
                            n_phase = PH_TYPE;
                        end else if (i_byte == i_head_first) begin
                            drop_inc = 3'd1;
                        end else begin
                            drop_inc = 3'd2;
                            n_held   = 1'b0;
                        end
                    end else if (i_byte == i_head_first) begin
                        n_held = 1'b1;
                    end else begin
                        drop_inc = 3'd1;
                    end
                end
                PH_TYPE: begin
                    n_type  = i_byte;
                    n_crc   = fpd_pkg::crc_add(fpd_pkg::CRC_INIT, i_byte);
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_byte;
                    n_crc   = fpd_pkg::crc_add(r_crc, i_byte);
                    n_phase = PH_SEQ;
                end
                PH_SEQ: begin
                    n_seq = i_byte;
                    if (r_len > MAX_LEN) begin
                        // False head: rescan type, length and sequence bytes
                        n_held = 1'b0;
                        n_crc  = fpd_pkg::CRC_INIT;
                        if (r_type == i_head_first && r_len == i_head_second) begin
                            drop_inc = 3'd1;
                            n_type   = i_byte;
                            n_crc    = fpd_pkg::crc_add(fpd_pkg::CRC_INIT, i_byte);
                            n_phase  = PH_LEN;
                        end else if (r_len == i_head_first && i_byte == i_head_second) begin
                            drop_inc = 3'd2;
                            n_phase  = PH_TYPE;
                        end else if (i_byte == i_head_first) begin
                            drop_inc = 3'd3;
                            n_held   = 1'b1;
                            n_phase  = PH_HUNT;
                        end else begin
                            drop_inc = 3'd4;
                            n_phase  = PH_HUNT;
                        end
                    end else begin
                        n_crc   = fpd_pkg::crc_add(r_crc, i_byte);
                        n_count = 8'd0;
                        n_phase = (r_len == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    wr_en   = (r_count < MAX_LEN);
                    n_crc   = fpd_pkg::crc_add(r_crc, i_byte);
                    n_count = r_count + 8'd1;
                    if (n_count >= r_len) begin
                        n_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    n_crc_lo = i_byte;
                    n_phase  = PH_CRC_HI;
                end
                default: begin
                    // CRC high byte closes the frame
                    n_phase = PH_HUNT;
                    n_held  = 1'b0;
                    if ({i_byte, r_crc_lo} == r_crc) begin
                        good_crc = 1'b1;
                    end else begin
                        bad_crc = 1'b1;
                    end
                end
            endcase
        end
    end

    // Advance counters
    always_comb begin
        n_counts.frames_ok  = r_counts.frames_ok + {31'd0, good_crc};
        n_counts.crc_errors = r_counts.crc_errors + {31'd0, bad_crc};
        n_counts.dropped    = r_counts.dropped + {29'd0, drop_inc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_held   <= 1'b0;
            r_type   <= 8'd0;
            r_len    <= 8'd0;
            r_seq    <= 8'd0;
            r_count  <= 8'd0;
            r_crc    <= fpd_pkg::CRC_INIT;
            r_crc_lo <= 8'd0;
            r_counts <= '0;
        end else begin
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_type   <= n_type;
            r_len    <= n_len;
            r_seq    <= n_seq;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
            r_counts <= n_counts;
        end
    end

    // Report outcome to the top level
    always_comb begin
        o_prs.wr_en       = wr_en;
        o_prs.wr_addr     = r_count;
        o_prs.wr_data     = i_byte;
        o_prs.emit        = good_crc && (r_len != 8'd0);
        o_prs.empty_ok    = good_crc && (r_len == 8'd0);
        o_prs.counts_next = n_counts;
        o_prs.counts      = r_counts;
        o_prs.frame_type  = r_type;
        o_prs.frame_seq   = r_seq;
        o_prs.frame_len   = r_len;
    end

endmodule

### hdl/framed_packet_deframer_crc16_top.sv
`timescale 1ns / 1ps

// Byte stream deframer with CRC-16/MODBUS check.
// Slave channel (i_s_*): one received byte per transfer in tdata.
// Master channel (o_m_*): result items; tuser is the kind (1 = payload byte or
// good empty frame), tlast marks the final result caused by one input byte.
// Config channel (i_cfg_*): index 0 writes the first head byte, index 1 the
// second; other indexes are ignored. Always ready; write only while idle.
// Every input byte but the CRC high byte of a good frame with payload gives one
// status result, registered into the output register at its transfer; a byte
// stream with no good frame end runs at one byte per cycle while results are taken.
// A good frame with N payload bytes streams N results from the payload
// memory through the read register into the output register after the CRC high
// byte, one per cycle while the receiver takes them; the single read port of
// that memory sets the pace, and input is held off until the last of them is
// loaded (an empty frame gives one result like any status byte).
// Receiver stalls hold the output register and, through it, the input side.
// Reset sets the head to 0xAA 0x55, clears the counters and returns to head
// hunting; the payload memory is not cleared and needs no clearing pass.
module framed_packet_deframer_crc16_top #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] data_byte
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] frame_type, [15:8] frame_seq, [21:16] payload_length,
    // [26:22] byte_index, [34:27] payload_byte, [66:35] frames_ok,
    // [98:67] crc_errors, [130:99] dropped_bytes, [135:131] zero
    output logic [fpd_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tuser,   // [0] kind
    output logic                            o_m_tlast,   // last
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    localparam int unsigned MEM_AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]        r_head_first;
    logic [7:0]        r_head_second;
    fpd_pkg::t_prs_out prs;

    logic [7:0] r_mem [MAX_PAYLOAD];
    logic       r_emitting;
    logic [7:0] r_iss_idx;
    logic       r_rd_valid;
    logic [7:0] r_rd_idx;
    logic [7:0] r_rd_data;

    logic                          r_out_valid;
    logic [fpd_pkg::M_TDATA_W-1:0] r_out_data;
    logic                          r_out_kind;
    logic                          r_out_last;

    logic out_free;
    logic take;
    logic issue;
    logic load_rd;
    logic rd_last;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_emitting && out_free;
    assign take       = i_s_tvalid && o_s_tready;
    assign load_rd    = r_rd_valid && out_free;
    assign issue      = r_emitting && (r_iss_idx < prs.frame_len) && (!r_rd_valid || load_rd);
    assign rd_last    = (8'(r_rd_idx + 8'd1) == prs.frame_len);

    // Configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first  <= fpd_pkg::HEAD_FIRST_RST;
            r_head_second <= fpd_pkg::HEAD_SECOND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fpd_pkg::CFG_HEAD_FIRST:  r_head_first  <= i_cfg_data;
                fpd_pkg::CFG_HEAD_SECOND: r_head_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fpd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_byte        (i_s_tdata),
        .i_head_first  (r_head_first),
        .i_head_second (r_head_second),
        .o_prs         (prs)
    );

    // Payload memory: write from the parser, registered read for streaming
    always_ff @(posedge i_clk) begin
        if (prs.wr_en) begin
            r_mem[prs.wr_addr[MEM_AW-1:0]] <= prs.wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_iss_idx[MEM_AW-1:0]];
            r_rd_idx  <= r_iss_idx;
        end
    end

    // Payload read sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitting <= 1'b0;
            r_iss_idx  <= 8'd0;
            r_rd_valid <= 1'b0;
        end else begin
            if (take && prs.emit) begin
                r_emitting <= 1'b1;
                r_iss_idx  <= 8'd0;
            end else if (issue) begin
                r_iss_idx <= r_iss_idx + 8'd1;
            end
            if (issue) begin
                r_rd_valid <= 1'b1;
            end else if (load_rd) begin
                r_rd_valid <= 1'b0;
            end
            if (load_rd && rd_last) begin
                r_emitting <= 1'b0;
            end
        end
    end

    // Output register: valid is control, fields are payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((take && !prs.emit) || load_rd) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !prs.emit) begin
            r_out_kind <= prs.empty_ok;
            r_out_last <= 1'b1;
            r_out_data <= {5'd0,
                           prs.counts_next.dropped,
                           prs.counts_next.crc_errors,
                           prs.counts_next.frames_ok,
                           8'd0,
                           5'd0,
                           prs.empty_ok ? prs.frame_len[5:0] : 6'd0,
                           prs.empty_ok ? prs.frame_seq : 8'd0,
                           prs.empty_ok ? prs.frame_type : 8'd0};
        end else if (load_rd) begin
            r_out_kind <= 1'b1;
            r_out_last <= rd_last;
            r_out_data <= {5'd0,
                           prs.counts.dropped,
                           prs.counts.crc_errors,
                           prs.counts.frames_ok,
                           r_rd_data,
                           r_rd_idx[4:0],
                           prs.frame_len[5:0],
                           prs.frame_seq,
                           prs.frame_type};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule
